// File: rtl/twr_pkg.sv
// Shared constants, codes and control structs of the ranging responder.
package twr_pkg;

    // Frame header constants
    localparam logic [15:0] FC_DATA_SHORT = 16'h8841;
    localparam logic [7:0]  FN_POLL       = 8'h21;
    localparam logic [7:0]  FN_FINAL      = 8'h23;
    localparam logic        OP_TIMEOUT    = 1'b1;

    // Field and datapath widths
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int RX_W       = 40;
    localparam int TS_W       = 32;
    localparam int DEN_W      = 34;
    localparam int PROD_W     = 64;
    localparam int DIST_SHIFT = 12;
    // delay * 65536 >> 8 is delay << 8
    localparam int DELAY_SHIFT = 8;
    localparam int DIV_STEPS   = PROD_W;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PAN   = 3'd0;
    localparam t_cfg_idx CFG_OWN   = 3'd1;
    localparam t_cfg_idx CFG_PEER  = 3'd2;
    localparam t_cfg_idx CFG_DELAY = 3'd3;
    localparam t_cfg_idx CFG_SCALE = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_PAN   = 16'hDECA;
    localparam logic [CFG_W-1:0] RST_OWN   = 16'h4157;
    localparam logic [CFG_W-1:0] RST_PEER  = 16'h4556;
    localparam logic [CFG_W-1:0] RST_DELAY = 16'd2600;
    localparam logic [CFG_W-1:0] RST_SCALE = 16'd19212;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_IGNORED = 3'd0;
    localparam t_status ST_POLL_OK = 3'd1;
    localparam t_status ST_RANGE   = 3'd2;
    localparam t_status ST_REJECT  = 3'd3;
    localparam t_status ST_TIMEOUT = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    load_diff;
        logic    keep_poll;
        logic    mul_rr;
        logic    mul_dd;
        logic    mul_scale;
        logic    div_init;
        logic    div_step;
        logic    sat_load;
        logic    dist_load;
        logic    out_load;
        t_status res;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic timeout;
        logic match_poll;
        logic match_final;
        logic den_zero;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/twr_ctrl.sv
// Sequencing state machine of the ranging responder.
module twr_ctrl
    import twr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_MUL_A = 4'd2;
    localparam logic [3:0] S_MUL_B = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SAT   = 4'd6;
    localparam logic [3:0] S_MUL_C = 4'd7;
    localparam logic [3:0] S_DIST  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_await, n_await;
    t_status          r_res, n_res;
    logic             w_in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_await = r_await;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.res = r_res;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = w_in_acc;
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.load_diff = 1'b1;
                n_state = S_OUT;
                if (i_stat.timeout) begin
                    n_res   = ST_TIMEOUT;
                    n_await = 1'b0;
                end else if (!r_await) begin
                    if (i_stat.match_poll) begin
                        n_res           = ST_POLL_OK;
                        n_await         = 1'b1;
                        o_cmd.keep_poll = 1'b1;
                    end else begin
                        n_res = ST_IGNORED;
                    end
                end else begin
                    n_res   = ST_REJECT;
                    n_await = 1'b0;
                    if (i_stat.match_final) begin
                        n_state = S_MUL_A;
                    end
                end
            end
            S_MUL_A: begin
                o_cmd.mul_rr = 1'b1;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_dd = 1'b1;
                // zero denominator: answer as rejected final
                n_state = i_stat.den_zero ? S_OUT : S_DIFF;
            end
            S_DIFF: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.sat_load = 1'b1;
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                o_cmd.mul_scale = 1'b1;
                n_state = S_DIST;
            end
            S_DIST: begin
                o_cmd.dist_load = 1'b1;
                n_res   = ST_RANGE;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_await <= 1'b0;
            r_res   <= ST_IGNORED;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_await <= n_await;
            r_res   <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_EVAL)
        else $error("accepted item did not enter evaluation");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("output loaded while occupied and stalled");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIV_LAST) |=> r_state == S_SAT)
        else $error("divider did not finish after its last step");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && i_stat.timeout) |=> !r_await)
        else $error("timeout did not return to poll wait");
`endif

endmodule

// File: rtl/twr_dp.sv
// Datapath of the ranging responder: header match, multiplier, divider, output register.
module twr_dp
    import twr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_opcode,
    input  logic [15:0]          i_frame_control,
    input  logic [15:0]          i_frame_pan,
    input  logic [15:0]          i_dest_address,
    input  logic [15:0]          i_src_address,
    input  logic [7:0]           i_function_code,
    input  logic [RX_W-1:0]      i_rx_stamp,
    input  logic [RX_W-1:0]      i_reply_tx_stamp,
    input  logic [TS_W-1:0]      i_poll_tx_stamp,
    input  logic [TS_W-1:0]      i_reply_rx_stamp,
    input  logic [TS_W-1:0]      i_final_tx_stamp,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic                 o_send_reply,
    output logic [TS_W-1:0]      o_reply_time,
    output logic                 o_range_valid,
    output logic signed [TS_W-1:0] o_tof_units,
    output logic signed [TS_W-1:0] o_distance_mm
);

    localparam logic [TS_W-1:0] SAT_MAX = {1'b0, {(TS_W-1){1'b1}}};
    localparam logic [TS_W-1:0] SAT_MIN = {1'b1, {(TS_W-1){1'b0}}};
    localparam int DMAG_W = PROD_W - DIST_SHIFT - 16;

    // Configuration registers
    logic [CFG_W-1:0] r_cfg_pan, r_cfg_own, r_cfg_peer, r_cfg_delay, r_cfg_scale;

    // Captured item
    logic            r_op;
    logic [15:0]     r_fc, r_pan, r_dst, r_src;
    logic [7:0]      r_fn;
    logic [RX_W-1:0] r_rx;
    logic [TS_W-1:0] r_rtx, r_ptx, r_rrx, r_ftx;
    logic [TS_W-1:0] r_poll_rx;

    // Ranging arithmetic
    logic [TS_W-1:0]   r_ra, r_rb, r_da, r_db;
    logic [DEN_W-1:0]  r_den;
    logic [PROD_W-1:0] r_pa, r_pb;
    logic [PROD_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic              r_neg;
    logic [TS_W-1:0]   r_tof, r_tmag, r_dist;
    logic              r_negd;
    logic              r_out_valid;

    logic              w_hdr;
    logic [TS_W-1:0]   w_ma, w_mb;
    logic [PROD_W-1:0] w_prod;
    logic              w_neg;
    logic [PROD_W-1:0] w_mag;
    logic [DEN_W:0]    w_shift, w_trial;
    logic              w_fit;
    logic              w_negq, w_qbig;
    logic [TS_W-1:0]   w_tof, w_tmag;
    logic [DMAG_W-1:0] w_dmag;
    logic              w_negd, w_dbig;
    logic [TS_W-1:0]   w_dist;
    logic [TS_W-1:0]   w_rtime;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pan   <= RST_PAN;
            r_cfg_own   <= RST_OWN;
            r_cfg_peer  <= RST_PEER;
            r_cfg_delay <= RST_DELAY;
            r_cfg_scale <= RST_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAN:   r_cfg_pan   <= i_cfg_data;
                CFG_OWN:   r_cfg_own   <= i_cfg_data;
                CFG_PEER:  r_cfg_peer  <= i_cfg_data;
                CFG_DELAY: r_cfg_delay <= i_cfg_data;
                CFG_SCALE: r_cfg_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_opcode;
            r_fc  <= i_frame_control;
            r_pan <= i_frame_pan;
            r_dst <= i_dest_address;
            r_src <= i_src_address;
            r_fn  <= i_function_code;
            r_rx  <= i_rx_stamp;
            r_rtx <= i_reply_tx_stamp[TS_W-1:0];
            r_ptx <= i_poll_tx_stamp;
            r_rrx <= i_reply_rx_stamp;
            r_ftx <= i_final_tx_stamp;
        end
    end

    // Keep the low poll receive time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_rx <= '0;
        end else if (i_cmd.keep_poll) begin
            r_poll_rx <= r_rx[TS_W-1:0];
        end
    end

    // Header match
    assign w_hdr = (r_op != OP_TIMEOUT) && (r_fc == FC_DATA_SHORT) &&
                   (r_pan == r_cfg_pan) && (r_dst == r_cfg_own) &&
                   (r_src == r_cfg_peer);

    assign o_stat.timeout     = (r_op == OP_TIMEOUT);
    assign o_stat.match_poll  = w_hdr && (r_fn == FN_POLL);
    assign o_stat.match_final = w_hdr && (r_fn == FN_FINAL);
    assign o_stat.den_zero    = (r_den == '0);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    // Wrapping round and reply intervals
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_diff) begin
            r_ra <= r_rrx - r_ptx;
            r_rb <= r_rx[TS_W-1:0] - r_rtx;
            r_da <= r_ftx - r_rrx;
            r_db <= r_rtx - r_poll_rx;
        end
    end

    // Shared multiplier: Ra*Rb, then Da*Db, then tof magnitude times scale
    always_comb begin
        if (i_cmd.mul_dd) begin
            w_ma = r_da;
            w_mb = r_db;
        end else if (i_cmd.mul_scale) begin
            w_ma = r_tmag;
            w_mb = TS_W'(r_cfg_scale);
        end else begin
            w_ma = r_ra;
            w_mb = r_rb;
        end
    end

    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_rr || i_cmd.mul_scale) begin
            r_pa <= w_prod;
        end
        if (i_cmd.mul_dd) begin
            r_pb <= w_prod;
        end
        if (i_cmd.mul_rr) begin
            r_den <= DEN_W'(r_ra) + DEN_W'(r_rb) + DEN_W'(r_da) + DEN_W'(r_db);
        end
    end

    // Signed numerator as sign and magnitude
    assign w_neg = (r_pa < r_pb);
    assign w_mag = w_neg ? (r_pb - r_pa) : (r_pa - r_pb);

    // Restoring divider, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[PROD_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_neg <= w_neg;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fit ? w_trial[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_fit};
        end
    end

    // Saturate the quotient to signed 32 bits
    assign w_negq = r_neg && (r_quo != '0);
    assign w_qbig = |r_quo[PROD_W-1:TS_W-1];

    always_comb begin
        if (w_negq) begin
            w_tof  = w_qbig ? SAT_MIN : (~r_quo[TS_W-1:0] + 1'b1);
            w_tmag = w_qbig ? SAT_MIN : r_quo[TS_W-1:0];
        end else begin
            w_tof  = w_qbig ? SAT_MAX : r_quo[TS_W-1:0];
            w_tmag = w_tof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sat_load) begin
            r_tof  <= w_tof;
            r_tmag <= w_tmag;
            r_negd <= w_negq;
        end
    end

    // Scale to millimetres and saturate
    assign w_dmag = r_pa[DMAG_W+DIST_SHIFT-1:DIST_SHIFT];
    assign w_negd = r_negd && (w_dmag != '0);
    assign w_dbig = |w_dmag[DMAG_W-1:TS_W-1];

    always_comb begin
        if (w_negd) begin
            w_dist = w_dbig ? SAT_MIN : (~w_dmag[TS_W-1:0] + 1'b1);
        end else begin
            w_dist = w_dbig ? SAT_MAX : w_dmag[TS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_load) begin
            r_dist <= w_dist;
        end
    end

    // Delayed reply time
    assign w_rtime = r_rx[RX_W-1:DELAY_SHIFT] + TS_W'({r_cfg_delay, {DELAY_SHIFT{1'b0}}});

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= i_cmd.res;
            o_send_reply  <= (i_cmd.res == ST_POLL_OK);
            o_reply_time  <= (i_cmd.res == ST_POLL_OK) ? w_rtime : '0;
            o_range_valid <= (i_cmd.res == ST_RANGE);
            o_tof_units   <= (i_cmd.res == ST_RANGE) ? $signed(r_tof) : '0;
            o_distance_mm <= (i_cmd.res == ST_RANGE) ? $signed(r_dist) : '0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/twr_responder_tof_unit.sv
// Two-way ranging responder: poll handling, reply timing, time of flight and distance.
// Timeout, ignored, poll and mismatched items go from evaluation to the output state; a
// final with all intervals zero passes the two multiplies first; a matching final adds the
// divide, saturate, scale and distance states. One item at a time: the next is taken in the
// cycle after the result is loaded, so an output stall also holds off the next item.
// Reset (synchronous, active low) empties the output, restores defaults, waits for a poll.
module twr_responder_tof_unit
    import twr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_opcode,
    input  logic [15:0]            i_frame_control,
    input  logic [15:0]            i_frame_pan,
    input  logic [15:0]            i_dest_address,
    input  logic [15:0]            i_src_address,
    input  logic [7:0]             i_function_code,
    input  logic [RX_W-1:0]        i_rx_stamp,
    input  logic [RX_W-1:0]        i_reply_tx_stamp,
    input  logic [TS_W-1:0]        i_poll_tx_stamp,
    input  logic [TS_W-1:0]        i_reply_rx_stamp,
    input  logic [TS_W-1:0]        i_final_tx_stamp,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [2:0]             o_status,
    output logic                   o_send_reply,
    output logic [TS_W-1:0]        o_reply_time,
    output logic                   o_range_valid,
    output logic signed [TS_W-1:0] o_tof_units,
    output logic signed [TS_W-1:0] o_distance_mm,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    twr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and result register
    twr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (i_opcode),
        .i_frame_control  (i_frame_control),
        .i_frame_pan      (i_frame_pan),
        .i_dest_address   (i_dest_address),
        .i_src_address    (i_src_address),
        .i_function_code  (i_function_code),
        .i_rx_stamp       (i_rx_stamp),
        .i_reply_tx_stamp (i_reply_tx_stamp),
        .i_poll_tx_stamp  (i_poll_tx_stamp),
        .i_reply_rx_stamp (i_reply_rx_stamp),
        .i_final_tx_stamp (i_final_tx_stamp),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_send_reply     (o_send_reply),
        .o_reply_time     (o_reply_time),
        .o_range_valid    (o_range_valid),
        .o_tof_units      (o_tof_units),
        .o_distance_mm    (o_distance_mm)
    );

endmodule

// File: verif/twr_responder_tof_unit_tb.sv
// Self-checking testbench for the ranging responder: random DS-TWR exchanges against a predictor.
`timescale 1ns / 1ps

module twr_responder_tof_unit_tb;
    import twr_pkg::*;

    localparam int       LIMIT_CYCLES = 1_000_000;
    localparam int       HOLD_CYCLES  = 400;
    localparam int       PHASE_ITEMS  = 275;
    localparam logic     OP_FRAME     = 1'b0;
    localparam t_cfg_idx CFG_SPARE    = 3'd7;

    // One received frame or timeout, as offered to the block
    typedef struct packed {
        logic        op;
        logic [15:0] fc;
        logic [15:0] pan;
        logic [15:0] dst;
        logic [15:0] src;
        logic [7:0]  fn;
        logic [39:0] rx;
        logic [39:0] rtx;
        logic [31:0] ptx;
        logic [31:0] rrx;
        logic [31:0] ftx;
    } t_frame;

    // Expected response to one frame
    typedef struct packed {
        t_status     status;
        logic        send;
        logic [31:0] rtime;
        logic        valid;
        logic [31:0] tof;
        logic [31:0] dist_mm;
    } t_outcome;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic           opcode = 1'b0;
    logic [15:0]    frame_control = '0;
    logic [15:0]    frame_pan = '0;
    logic [15:0]    dest_address = '0;
    logic [15:0]    src_address = '0;
    logic [7:0]     function_code = '0;
    logic [39:0]    rx_stamp = '0;
    logic [39:0]    reply_tx_stamp = '0;
    logic [31:0]    poll_tx_stamp = '0;
    logic [31:0]    reply_rx_stamp = '0;
    logic [31:0]    final_tx_stamp = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic [2:0]     status;
    logic           send_reply;
    logic [31:0]    reply_time;
    logic           range_valid;
    logic signed [31:0] tof_units;
    logic signed [31:0] distance_mm;
    logic           cfg_we = 1'b0;
    t_cfg_idx       cfg_index = CFG_PAN;
    logic [15:0]    cfg_data = '0;

    // Predictor state and register copies
    logic           waiting_final = 1'b0;
    logic [31:0]    poll_rx_lo = '0;
    logic [15:0]    cfg_pan = RST_PAN;
    logic [15:0]    cfg_own = RST_OWN;
    logic [15:0]    cfg_peer = RST_PEER;
    logic [15:0]    cfg_delay = RST_DELAY;
    logic [15:0]    cfg_scale = RST_SCALE;

    t_frame         pending_frames[$];
    t_outcome       expected_outcomes[$];
    t_frame         on_bus;
    t_outcome       want;
    int             n_queued = 0;
    int             n_accepted = 0;
    int             fail_count = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             hold_req = 0;
    int             hold_seen = 0;
    int             hold_left = 0;
    int             status_seen[8];

    twr_responder_tof_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_frame_control  (frame_control),
        .i_frame_pan      (frame_pan),
        .i_dest_address   (dest_address),
        .i_src_address    (src_address),
        .i_function_code  (function_code),
        .i_rx_stamp       (rx_stamp),
        .i_reply_tx_stamp (reply_tx_stamp),
        .i_poll_tx_stamp  (poll_tx_stamp),
        .i_reply_rx_stamp (reply_rx_stamp),
        .i_final_tx_stamp (final_tx_stamp),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_send_reply     (send_reply),
        .o_reply_time     (reply_time),
        .o_range_valid    (range_valid),
        .o_tof_units      (tof_units),
        .o_distance_mm    (distance_mm),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    // Clamp a sign/magnitude value into signed 32 bits
    function automatic logic [31:0] clamp_s32(input logic negative, input logic [63:0] mag);
        if (negative) begin
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic header_ok(input t_frame f, input logic [7:0] code);
        return f.fc == FC_DATA_SHORT && f.pan == cfg_pan && f.dst == cfg_own &&
               f.src == cfg_peer && f.fn == code;
    endfunction

    // Advance the responder state by one frame and give the expected response
    function automatic t_outcome respond_to_frame(input t_frame f);
        t_outcome    r;
        logic [31:0] ra, rb, da, db;
        logic [63:0] den, p1, p2, mag, q, tmag, dmag, tsum;
        logic        neg;
        r = '0;
        if (f.op == OP_TIMEOUT) begin
            r.status = ST_TIMEOUT;
            waiting_final = 1'b0;
        end else if (!waiting_final) begin
            if (header_ok(f, FN_POLL)) begin
                tsum = {24'b0, f.rx} + ({48'b0, cfg_delay} << 16);
                poll_rx_lo = f.rx[31:0];
                r.rtime = tsum[39:8];
                r.send = 1'b1;
                r.status = ST_POLL_OK;
                waiting_final = 1'b1;
            end
        end else begin
            waiting_final = 1'b0;
            r.status = ST_REJECT;
            if (header_ok(f, FN_FINAL)) begin
                ra = f.rrx - f.ptx;
                rb = f.rx[31:0] - f.rtx[31:0];
                da = f.ftx - f.rrx;
                db = f.rtx[31:0] - poll_rx_lo;
                den = {32'b0, ra} + {32'b0, rb} + {32'b0, da} + {32'b0, db};
                if (den != 0) begin
                    p1 = {32'b0, ra} * {32'b0, rb};
                    p2 = {32'b0, da} * {32'b0, db};
                    neg = p1 < p2;
                    mag = neg ? p2 - p1 : p1 - p2;
                    q = mag / den;
                    neg = neg && q != 0;
                    r.tof = clamp_s32(neg, q);
                    tmag = {32'b0, neg ? 32'd0 - r.tof : r.tof};
                    dmag = (tmag * {48'b0, cfg_scale}) >> DIST_SHIFT;
                    r.dist_mm = clamp_s32(neg && dmag != 0, dmag);
                    r.valid = 1'b1;
                    r.status = ST_RANGE;
                end
            end
        end
        return r;
    endfunction

    function automatic t_frame noise_frame();
        t_frame f;
        f.op  = 1'($urandom_range(1));
        f.fc  = 16'($urandom);
        f.pan = 16'($urandom);
        f.dst = 16'($urandom);
        f.src = 16'($urandom);
        f.fn  = 8'($urandom);
        f.rx  = 40'({$urandom, $urandom});
        f.rtx = 40'({$urandom, $urandom});
        f.ptx = $urandom;
        f.rrx = $urandom;
        f.ftx = $urandom;
        return f;
    endfunction

    function automatic t_frame header_frame(input logic [7:0] code);
        t_frame f;
        f = noise_frame();
        f.op  = OP_FRAME;
        f.fc  = FC_DATA_SHORT;
        f.pan = cfg_pan;
        f.dst = cfg_own;
        f.src = cfg_peer;
        f.fn  = code;
        return f;
    endfunction

    // Build a final whose four round/reply intervals come out as given
    function automatic t_frame final_frame(input logic [39:0] poll_rx,
                                           input logic [31:0] ra, rb, da, db);
        t_frame f;
        f = header_frame(FN_FINAL);
        f.ptx = $urandom;
        f.rrx = f.ptx + ra;
        f.ftx = f.rrx + da;
        f.rtx[31:0] = poll_rx[31:0] + db;
        f.rx[31:0] = f.rtx[31:0] + rb;
        return f;
    endfunction

    // Break exactly one header field
    function automatic t_frame spoil_header(input t_frame f);
        logic [15:0] x;
        logic [7:0]  y;
        x = 16'($urandom_range(65535, 1));
        y = 8'($urandom_range(255, 1));
        case ($urandom_range(4))
            0: f.fc ^= x;
            1: f.pan ^= x;
            2: f.dst ^= x;
            3: f.src ^= x;
            default: f.fn ^= y;
        endcase
        return f;
    endfunction

    function automatic void offer(input t_frame f);
        pending_frames.push_back(f);
        n_queued++;
    endfunction

    // Queue one exchange, mostly well formed; report how many items do real work
    task automatic queue_exchange(output int counted);
        t_frame      poll, fin;
        logic [31:0] ra, rb, da, db, flight;
        int          kind;
        kind = $urandom_range(99);
        poll = header_frame(FN_POLL);
        flight = $urandom_range(20000);
        db = $urandom_range(32'h00FF_FFFF, 32'h0000_1000);
        da = $urandom_range(32'h00FF_FFFF, 32'h0000_1000);
        ra = db + 2 * flight + $urandom_range(40);
        rb = da + 2 * flight + $urandom_range(40);
        if (kind < 20) begin
            // wild intervals: any sign, large magnitudes
            ra = $urandom;
            rb = $urandom;
            da = $urandom;
            db = $urandom;
        end else if (kind < 22) begin
            ra = '0;
            rb = '0;
            da = '0;
            db = '0;
        end
        fin = final_frame(poll.rx, ra, rb, da, db);
        counted = 2;
        if (kind < 65) begin
            offer(poll);
            offer(fin);
        end else if (kind < 72) begin
            offer(poll);
            offer(spoil_header(fin));
        end else if (kind < 76) begin
            offer(poll);
            fin.op = OP_TIMEOUT;
            offer(fin);
        end else if (kind < 79) begin
            offer(poll);
            offer(header_frame(FN_POLL));
        end else if (kind < 86) begin
            fin = noise_frame();
            fin.op = OP_TIMEOUT;
            offer(fin);
            counted = 1;
        end else if (kind < 93) begin
            offer(spoil_header(poll));
            counted = 0;
        end else if (kind < 96) begin
            offer(fin);
            counted = 0;
        end else begin
            fin = noise_frame();
            fin.op = OP_FRAME;
            offer(fin);
            counted = 0;
        end
    endtask

    task automatic queue_random_phase(input int target);
        int made, n;
        made = 0;
        while (made < target) begin
            queue_exchange(n);
            made += n;
        end
    endtask

    // Hold off until every queued item is in and every result is out
    task automatic wait_drained(input int settle);
        while (n_accepted != n_queued || expected_outcomes.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write all registers, plus a write to an unused index that must change nothing
    task automatic set_config(input logic [15:0] pan, own, peer, dly, scl);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PAN;
        cfg_data <= pan;
        cfg_pan = pan;
        @(posedge clk);
        cfg_index <= CFG_OWN;
        cfg_data <= own;
        cfg_own = own;
        @(posedge clk);
        cfg_index <= CFG_PEER;
        cfg_data <= peer;
        cfg_peer = peer;
        @(posedge clk);
        cfg_index <= CFG_DELAY;
        cfg_data <= dly;
        cfg_delay = dly;
        @(posedge clk);
        cfg_index <= CFG_SCALE;
        cfg_data <= scl;
        cfg_scale = scl;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: predict on acceptance, then present the next item or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_outcomes.push_back(respond_to_frame(on_bus));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_frames.pop_front();
                    in_valid <= 1'b1;
                    opcode <= on_bus.op;
                    frame_control <= on_bus.fc;
                    frame_pan <= on_bus.pan;
                    dest_address <= on_bus.dst;
                    src_address <= on_bus.src;
                    function_code <= on_bus.fn;
                    rx_stamp <= on_bus.rx;
                    reply_tx_stamp <= on_bus.rtx;
                    poll_tx_stamp <= on_bus.ptx;
                    reply_rx_stamp <= on_bus.rrx;
                    final_tx_stamp <= on_bus.ftx;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string what, input logic [31:0] want_v, got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, status);
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    status_seen[want.status]++;
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("send_reply", 32'(want.send), 32'(send_reply));
                    check_field("reply_time", want.rtime, reply_time);
                    check_field("range_valid", 32'(want.valid), 32'(range_valid));
                    check_field("tof_units", want.tof, tof_units);
                    check_field("distance_mm", want.dist_mm, distance_mm);
                end
            end
            // long hold-off on request, else random stalls
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("twr_responder_tof_unit test failed");
            $finish;
        end
    end

    initial begin
        t_frame p, f;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 22;
        recv_idle_pct = 73;

        // Directed part under reset register values
        f = noise_frame();
        f.op = OP_TIMEOUT;
        offer(f);                                   // timeout while waiting for poll
        offer(t_frame'('0));                        // all-zero frame
        f = '1;
        f.op = OP_FRAME;
        offer(f);                                   // all-ones frame
        p = header_frame(FN_POLL);
        p.rx = '1;                                  // reply time wraps
        offer(p);
        offer(final_frame(p.rx, 32'd300100, 32'd200100, 32'd200000, 32'd300000));
        p = header_frame(FN_POLL);
        p.rx = '0;
        offer(p);
        f = noise_frame();
        f.op = OP_TIMEOUT;
        offer(f);                                   // timeout while waiting for final
        offer(header_frame(FN_FINAL));              // final with no poll before it
        p = header_frame(FN_POLL);
        offer(p);
        f = final_frame(p.rx, 32'd5000, 32'd5000, 32'd4000, 32'd4000);
        f.src ^= 16'h8000;
        offer(f);                                   // final from the wrong peer
        p = header_frame(FN_POLL);
        offer(p);
        offer(final_frame(p.rx, '0, '0, '0, '0));   // zero denominator
        p = header_frame(FN_POLL);
        offer(p);
        offer(final_frame(p.rx, '1, '1, '0, '0));   // largest positive flight
        p = header_frame(FN_POLL);
        offer(p);
        offer(final_frame(p.rx, '0, '0, '1, '1));   // largest negative flight
        p = header_frame(FN_POLL);
        offer(p);
        offer(final_frame(p.rx, '0, '0, 32'd1, 32'd1)); // negative, truncates to zero
        p = header_frame(FN_POLL);
        offer(p);
        offer(header_frame(FN_POLL));               // second poll instead of final
        f = header_frame(FN_POLL);
        f.fc ^= 16'h0001;
        offer(f);
        f = header_frame(FN_POLL);
        f.pan ^= 16'h0100;
        offer(f);
        f = header_frame(FN_POLL);
        f.dst ^= 16'h0010;
        offer(f);
        f = header_frame(FN_POLL);
        f.src ^= 16'h1000;
        offer(f);
        wait_drained(8);

        // Random phases over several register settings
        set_config('0, '0, '0, '0, '0);
        queue_random_phase(PHASE_ITEMS);
        wait_drained(8);
        set_config('1, '1, '1, '1, '1);
        queue_random_phase(PHASE_ITEMS);
        wait_drained(8);

        send_idle_pct = 73;
        recv_idle_pct = 22;
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        queue_random_phase(PHASE_ITEMS);
        wait_drained(8);

        // No gaps; block the output for a while so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        hold_req++;
        queue_random_phase(PHASE_ITEMS);
        wait_drained(100);

        $display("Ran %0d frames over five register settings: %0d polls, %0d ranges, %0d rejects,",
                 n_accepted, status_seen[ST_POLL_OK], status_seen[ST_RANGE],
                 status_seen[ST_REJECT]);
        $display("%0d timeouts, %0d ignored, with idle gaps on both sides and an output hold-off.",
                 status_seen[ST_TIMEOUT], status_seen[ST_IGNORED]);
        if (fail_count == 0) begin
            $display("twr_responder_tof_unit test passed");
        end else begin
            $display("twr_responder_tof_unit test failed");
        end
        $finish;
    end

endmodule
